@@ design/date_validate_and_day_difference_top_macros.svh @@
// Assertion macros for the date difference design, included by the day counter.
`ifndef DATE_VALIDATE_AND_DAY_DIFFERENCE_TOP_MACROS_SVH
`define DATE_VALIDATE_AND_DAY_DIFFERENCE_TOP_MACROS_SVH

// Same-cycle implication, checked on clk, off during reset.
`define DVD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk, off during reset.
`define DVD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/dvd_pkg.sv @@
// Types, constants and calendar tables for the date difference block.
package dvd_pkg;

  localparam int unsigned MAX_YEAR  = 9999;
  localparam int unsigned MAX_COUNT = 3652424;
  localparam logic [10:0] RECIP25   = 11'd1311;
  localparam logic [10:0] DAYS_YEAR = 11'd365;
  localparam logic [3:0]  MON_FEB   = 4'd2;
  localparam logic [3:0]  MON_DEC   = 4'd12;

  typedef struct packed {
    logic       pad;
    logic [4:0] day_b;
    logic [3:0] month_b;
    logic [13:0] year_b;
    logic [5:0] second_a;
    logic [5:0] minute_a;
    logic [4:0] hour_a;
    logic [4:0] day_a;
    logic [3:0] month_a;
    logic [13:0] year_a;
  } in_word_t;

  typedef struct packed {
    logic [13:0] year_a;
    logic [3:0]  month_a;
    logic [4:0]  day_a;
    logic [13:0] year_b;
    logic [3:0]  month_b;
    logic [4:0]  day_b;
    logic        leap_a;
    logic        leap_b;
    logic        date_a_ok;
    logic        time_a_ok;
    logic        date_b_ok;
  } entry_t;

  typedef struct packed {
    logic [6:0]  pad;
    logic [21:0] day_count;
    logic        date_b_ok;
    logic        time_a_ok;
    logic        date_a_ok;
  } out_word_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      MON_FEB:                                    len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] n;
    case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

@@ design/date_validate_and_day_difference_top.sv @@
// The day counter takes its eight steps on one shared multiplier, plus load and
// unload, per word, and takes no new word until its result is loaded; the input
// stage and two-entry queue run ahead of it independently.
// Reset: synchronous active-low rst_n empties the queue and all valid flags.
module date_validate_and_day_difference_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // year_a[13:0] month_a[17:14] day_a[22:18] hour_a[27:23] minute_a[33:28]
  // second_a[39:34] year_b[53:40] month_b[57:54] day_b[62:58] zero[63]
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // date_a_ok[0] time_a_ok[1] date_b_ok[2] day_count[24:3] zero[31:25]
  output logic [31:0] out_tdata
);
  import dvd_pkg::*;

  logic   push, q_full, pop, q_empty;
  entry_t push_entry, pop_entry;

  dvd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .push       (push),
    .push_entry (push_entry),
    .q_full     (q_full)
  );

  dvd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .empty      (q_empty)
  );

  dvd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_entry    (pop_entry),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

@@ design/dvd_front.sv @@
// Input stage: takes words, checks time and dates, emits classified entries.
module dvd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [63:0]         in_tdata,
  output logic                push,
  output dvd_pkg::entry_t     push_entry,
  input  logic                q_full
);
  import dvd_pkg::*;

  in_word_t   w_r;
  logic       s1_valid_r, s1_valid_nxt;
  logic [6:0] qa_r, qb_r;
  logic [22:0] prod_a, prod_b;
  logic       leap_a, leap_b;
  logic       accept;

  function automatic logic is_leap(input logic [13:0] y, input logic [6:0] q);
    logic div100;
    div100 = ({5'd0, q} * 12'd25) == y[13:2];
    return (y[1:0] == 2'b00) && (!div100 || (q[1:0] == 2'b00));
  endfunction

  function automatic logic date_ok(input logic [13:0] y, input logic [3:0] m,
                                   input logic [4:0] d, input logic leap);
    return (32'(y) <= MAX_YEAR) && (m != 4'd0) && (m <= MON_DEC) &&
           (d != 5'd0) && (d <= month_len(m, leap));
  endfunction

  assign in_tready = !s1_valid_r || !q_full;
  assign accept    = in_tvalid && in_tready;
  assign push      = s1_valid_r && !q_full;

  // y/100 = (y/4)/25 by reciprocal
  assign prod_a = 23'(in_tdata[13:2]) * 23'(RECIP25);
  assign prod_b = 23'(in_tdata[53:42]) * 23'(RECIP25);

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (push) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      w_r  <= in_word_t'(in_tdata);
      qa_r <= prod_a[21:15];
      qb_r <= prod_b[21:15];
    end
  end

  assign leap_a = is_leap(w_r.year_a, qa_r);
  assign leap_b = is_leap(w_r.year_b, qb_r);

  always_comb begin
    push_entry.year_a    = w_r.year_a;
    push_entry.month_a   = w_r.month_a;
    push_entry.day_a     = w_r.day_a;
    push_entry.year_b    = w_r.year_b;
    push_entry.month_b   = w_r.month_b;
    push_entry.day_b     = w_r.day_b;
    push_entry.leap_a    = leap_a;
    push_entry.leap_b    = leap_b;
    push_entry.date_a_ok = date_ok(w_r.year_a, w_r.month_a, w_r.day_a, leap_a);
    push_entry.date_b_ok = date_ok(w_r.year_b, w_r.month_b, w_r.day_b, leap_b);
    push_entry.time_a_ok = (w_r.hour_a <= 5'd23) && (w_r.minute_a <= 6'd59) &&
                           (w_r.second_a <= 6'd59);
  end

endmodule

@@ design/dvd_queue.sv @@
// Two-entry queue between the input stage and the day counter.
module dvd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  dvd_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output dvd_pkg::entry_t pop_entry,
  output logic            empty
);
  import dvd_pkg::*;

  entry_t     mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full      = cnt_r == 2'd2;
  assign empty     = cnt_r == 2'd0;
  assign pop_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

@@ design/dvd_back.sv @@
// Day counter: day numbers of both dates on a shared multiplier, then the distance.
module dvd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  dvd_pkg::entry_t q_entry,
  output logic            pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [31:0]     out_tdata
);
  import dvd_pkg::*;

  `include "date_validate_and_day_difference_top_macros.svh"

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [2:0]  step_r, step_nxt;
  entry_t      it_r;
  logic [21:0] acc_r, acc_nxt;
  logic [21:0] na_r;
  logic [24:0] prod_r, prod_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_word_t   out_data_r, out_data_nxt;

  logic [13:0] y;
  logic [3:0]  m;
  logic [4:0]  d;
  logic        lp;
  logic [14:0] y3, y99, y399;
  logic [13:0] mul_a;
  logic [10:0] mul_b;
  logic [21:0] diff;
  logic        out_free;

  assign y    = step_r[2] ? it_r.year_b  : it_r.year_a;
  assign m    = step_r[2] ? it_r.month_b : it_r.month_a;
  assign d    = step_r[2] ? it_r.day_b   : it_r.day_a;
  assign lp   = step_r[2] ? it_r.leap_b  : it_r.leap_a;
  assign y3   = {1'b0, y} + 15'd3;
  assign y99  = {1'b0, y} + 15'd99;
  assign y399 = {1'b0, y} + 15'd399;

  always_comb begin
    unique case (step_r[1:0])
      2'd0:    begin mul_a = y;                mul_b = DAYS_YEAR; end
      2'd1:    begin mul_a = {1'b0, y99[14:2]};  mul_b = RECIP25;   end
      default: begin mul_a = {1'b0, y399[14:2]}; mul_b = RECIP25;   end
    endcase
  end

  assign diff     = (na_r > acc_r) ? (na_r - acc_r) : (acc_r - na_r);
  assign out_free = !out_valid_r || out_tready;
  assign pop      = (state_r == ST_IDLE) && !q_empty;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    acc_nxt       = acc_r;
    prod_nxt      = 25'(mul_a) * 25'(mul_b);
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = ST_RUN;
          step_nxt  = 3'd0;
        end
      end
      ST_RUN: begin
        unique case (step_r[1:0])
          2'd0: acc_nxt = 22'(days_before(m)) + 22'(lp && (m > MON_FEB)) + 22'(d)
                          - 22'd1 + 22'(y3[14:2]);
          2'd1: acc_nxt = acc_r + prod_r[21:0];
          2'd2: acc_nxt = acc_r - 22'(prod_r[24:15]);
          default: acc_nxt = acc_r + 22'(prod_r[24:17]);
        endcase
        step_nxt = step_r + 3'd1;
        if (step_r == 3'd7) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.pad       = '0;
          out_data_nxt.date_a_ok = it_r.date_a_ok;
          out_data_nxt.time_a_ok = it_r.time_a_ok;
          out_data_nxt.date_b_ok = it_r.date_b_ok;
          out_data_nxt.day_count = (it_r.date_a_ok && it_r.date_b_ok) ? diff : 22'd0;
          state_nxt              = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      it_r <= q_entry;
    end
    if (state_r == ST_RUN && step_r == 3'd4) begin
      na_r <= acc_r;
    end
    acc_r      <= acc_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `DVD_ASSERT_IMP(a_count_needs_dates, out_valid_r && (out_data_r.day_count != 22'd0), out_data_r.date_a_ok && out_data_r.date_b_ok, "count with invalid date")
  `DVD_ASSERT_IMP(a_count_range, out_valid_r, 32'(out_data_r.day_count) <= MAX_COUNT, "count out of range")
  `DVD_ASSERT_NXT(a_done_loads, (state_r == ST_DONE) && out_free, out_valid_r && (state_r == ST_IDLE), "finished item not loaded")
  `DVD_ASSERT_NXT(a_pop_starts, pop, (state_r == ST_RUN) && (step_r == 3'd0), "popped item not started")

endmodule
